FILE: design/frustum_box_cull_macros.svh
// ---------------------------------------------------------------------------
// frustum box cull assertion macros
// shared concurrent assertion forms for the cull pipeline
// ---------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_CULL_MACROS_SVH
`define FRUSTUM_BOX_CULL_MACROS_SVH

// implication checked on every clock, off while in reset
`define FBC_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// next-cycle implication
`define FBC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

FILE: design/fbc_pkg.sv
// ---------------------------------------------------------------------------
// fbc package
// widths, plane types and constants for the frustum box cull
// ---------------------------------------------------------------------------
package fbc_pkg;
	localparam int NUM_PLANES  = 6;
	localparam int COORD_WIDTH = 32;
	localparam int NORM_W      = 16;
	localparam int OFS_W       = 48;
	localparam int IDX_W       = 3;
	localparam int PROD_W      = COORD_WIDTH + NORM_W;
	localparam int DIST_W      = PROD_W + 3;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TEST = 1'b1;
	localparam logic [IDX_W-1:0] PLANE_NONE = IDX_W'(NUM_PLANES);

	typedef struct packed {
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nz;
		logic signed [OFS_W-1:0]  ofs;
	} plane_t;

	typedef struct packed {
		logic                    kind;
		logic [IDX_W-1:0]        plane_index;
		logic signed [NORM_W-1:0] normal_x;
		logic signed [NORM_W-1:0] normal_y;
		logic signed [NORM_W-1:0] normal_z;
		logic signed [OFS_W-1:0]  plane_offset;
		logic signed [31:0]       min_x;
		logic signed [31:0]       min_y;
		logic signed [31:0]       min_z;
		logic signed [31:0]       max_x;
		logic signed [31:0]       max_y;
		logic signed [31:0]       max_z;
	} req_t;

	typedef struct packed {
		logic             visible;
		logic [IDX_W-1:0] rejecting_plane;
	} rsp_t;
endpackage

FILE: design/fbc_if.sv
// ---------------------------------------------------------------------------
// fbc channel interfaces
// valid/ready channels carrying request and response payloads
// ---------------------------------------------------------------------------
interface fbc_req_if import fbc_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fbc_rsp_if import fbc_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/frustum_box_cull.sv
// ---------------------------------------------------------------------------
// frustum box cull
// six-plane view-frustum test of axis-aligned boxes, one request per cycle
// ---------------------------------------------------------------------------
// req: one request per accepted valid/ready handshake. kind 0 loads plane
//   plane_index (indexes of 6 and above are dropped), kind 1 tests a box
// rsp: exactly one response per request, in request order
// pipeline: s1 captures the request and reads the plane file, s2 forms
//   the thirty-six normal-by-coordinate products, s3 picks the larger product
//   per axis and sums, s4 subtracts offsets and finds the first culling
//   plane and registers the response that drives rsp
// throughput: one request per cycle while rsp is taken
// plane loads write the plane file at stage one, so a test that follows a
//   load in the next cycle already sees the new plane
// reset clears all planes to zero, which culls every box at plane 0
// when the receiver stalls the whole pipeline holds and req.ready falls
// ---------------------------------------------------------------------------
`include "frustum_box_cull_macros.svh"

module frustum_box_cull import fbc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	fbc_req_if.sink   req,
	fbc_rsp_if.source rsp
);
	typedef logic signed [COORD_WIDTH-1:0] crd_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [DIST_W-1:0]      dist_t;

	plane_t planes_q [NUM_PLANES];

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;

	logic   kind_s1;
	crd_t   lo_s1 [3];
	crd_t   hi_s1 [3];
	plane_t pl_s1 [NUM_PLANES];

	logic  kind_s2;
	prod_t plo_s2 [NUM_PLANES][3];
	prod_t phi_s2 [NUM_PLANES][3];
	logic signed [OFS_W-1:0] ofs_s2 [NUM_PLANES];

	logic  kind_s3;
	dist_t sum_s3 [NUM_PLANES];
	logic signed [OFS_W-1:0] ofs_s3 [NUM_PLANES];

	rsp_t  rsp_s4;

	assign adv       = !v_s4 || rsp.ready;
	assign req.ready = adv;

	// plane file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++) planes_q[p] <= '0;
		end else if (req.valid && adv && req.data.kind == KIND_LOAD) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				if (req.data.plane_index == IDX_W'(p)) begin
					planes_q[p] <= '{req.data.normal_x, req.data.normal_y,
						req.data.normal_z, req.data.plane_offset};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: capture box, planes as they stood before any load of this cycle
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1  <= req.data.kind;
			lo_s1[0] <= crd_t'(req.data.min_x);
			lo_s1[1] <= crd_t'(req.data.min_y);
			lo_s1[2] <= crd_t'(req.data.min_z);
			hi_s1[0] <= crd_t'(req.data.max_x);
			hi_s1[1] <= crd_t'(req.data.max_y);
			hi_s1[2] <= crd_t'(req.data.max_z);
			for (int p = 0; p < NUM_PLANES; p++) pl_s1[p] <= planes_q[p];
		end
	end

	// stage 2: products
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= kind_s1;
			for (int p = 0; p < NUM_PLANES; p++) begin
				plo_s2[p][0] <= prod_t'(pl_s1[p].nx) * prod_t'(lo_s1[0]);
				phi_s2[p][0] <= prod_t'(pl_s1[p].nx) * prod_t'(hi_s1[0]);
				plo_s2[p][1] <= prod_t'(pl_s1[p].ny) * prod_t'(lo_s1[1]);
				phi_s2[p][1] <= prod_t'(pl_s1[p].ny) * prod_t'(hi_s1[1]);
				plo_s2[p][2] <= prod_t'(pl_s1[p].nz) * prod_t'(lo_s1[2]);
				phi_s2[p][2] <= prod_t'(pl_s1[p].nz) * prod_t'(hi_s1[2]);
				ofs_s2[p]    <= pl_s1[p].ofs;
			end
		end
	end

	// stage 3: per-axis maximum and sum
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s3 <= kind_s2;
			for (int p = 0; p < NUM_PLANES; p++) begin
				sum_s3[p] <=
					dist_t'((plo_s2[p][0] > phi_s2[p][0]) ? plo_s2[p][0] : phi_s2[p][0]) +
					dist_t'((plo_s2[p][1] > phi_s2[p][1]) ? plo_s2[p][1] : phi_s2[p][1]) +
					dist_t'((plo_s2[p][2] > phi_s2[p][2]) ? plo_s2[p][2] : phi_s2[p][2]);
				ofs_s3[p] <= ofs_s2[p];
			end
		end
	end

	// stage 4: offset compare and first culling plane
	logic [NUM_PLANES-1:0] cull;
	rsp_t res;
	always_comb begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			cull[p] = (sum_s3[p] - dist_t'(ofs_s3[p])) <= dist_t'(0);
		end
		res = '{1'b1, PLANE_NONE};
		for (int p = NUM_PLANES - 1; p >= 0; p--) begin
			if (cull[p]) res = '{1'b0, IDX_W'(p)};
		end
		if (kind_s3 == KIND_LOAD) res = '{1'b0, PLANE_NONE};
	end

	always_ff @(posedge clk) begin
		if (adv) rsp_s4 <= res;
	end

	assign rsp.valid = v_s4;
	assign rsp.data  = rsp_s4;

	`FBC_ASSERT_NEXT(a_hold, clk, arst_n, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data))
	`FBC_ASSERT_IMPL(a_ready, clk, arst_n, !rsp.valid, req.ready)
	`FBC_ASSERT_IMPL(a_vis, clk, arst_n, rsp.valid && rsp.data.visible, rsp.data.rejecting_plane == PLANE_NONE)
endmodule

FILE: verif/frustum_box_cull_test.sv
// ---------------------------------------------------------------------------
// frustum box cull testbench
// loads planes and tests boxes through the request channel, predicts each
// response from a local copy of the plane file and checks it in order
// ---------------------------------------------------------------------------
module frustum_box_cull_test;
	import fbc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		req_t r;
		logic has_exp;
		rsp_t e;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int errors = 0;
	int cycles = 0;
	bit hold_long = 1'b0;
	bit send_done = 1'b0;

	fbc_req_if req ();
	fbc_rsp_if rsp ();

	frustum_box_cull dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	plane_t planes [NUM_PLANES];
	rsp_t cull_expected [$];
	row_t rows [$];

	always #2 clk = ~clk;

	function automatic rsp_t cull_predict(req_t r);
		rsp_t o;
		longint lo [3];
		longint hi [3];
		longint nn [3];
		longint best;
		longint a;
		longint b;
		o.visible = 1'b0;
		o.rejecting_plane = PLANE_NONE;
		if (r.kind == KIND_LOAD) begin
			if (r.plane_index < NUM_PLANES) begin
				planes[r.plane_index].nx = r.normal_x;
				planes[r.plane_index].ny = r.normal_y;
				planes[r.plane_index].nz = r.normal_z;
				planes[r.plane_index].ofs = r.plane_offset;
			end
			return o;
		end
		lo[0] = r.min_x; lo[1] = r.min_y; lo[2] = r.min_z;
		hi[0] = r.max_x; hi[1] = r.max_y; hi[2] = r.max_z;
		for (int p = 0; p < NUM_PLANES; p++) begin
			nn[0] = planes[p].nx; nn[1] = planes[p].ny; nn[2] = planes[p].nz;
			best = 0;
			for (int k = 0; k < 3; k++) begin
				a = nn[k] * lo[k];
				b = nn[k] * hi[k];
				best += (a > b) ? a : b;
			end
			if (best - longint'(planes[p].ofs) <= 0) begin
				o.rejecting_plane = IDX_W'(p);
				return o;
			end
		end
		o.visible = 1'b1;
		return o;
	endfunction

	function automatic logic signed [15:0] rand_norm();
		case ($urandom_range(0, 5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd0;
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'($urandom);
			default: return 32'($signed($urandom_range(0, 32'h00200000)) - 32'sh00100000);
		endcase
	endfunction

	function automatic req_t rand_req(bit load);
		req_t r;
		r.kind = load ? KIND_LOAD : KIND_TEST;
		r.plane_index = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(0, 5));
		r.normal_x = rand_norm();
		r.normal_y = rand_norm();
		r.normal_z = rand_norm();
		if ($urandom_range(0, 3) == 0)
			r.plane_offset = 48'({$urandom, $urandom});
		else
			r.plane_offset = 48'($signed({$urandom, $urandom}) >>> 36);
		r.min_x = rand_coord(); r.min_y = rand_coord(); r.min_z = rand_coord();
		r.max_x = rand_coord(); r.max_y = rand_coord(); r.max_z = rand_coord();
		if ($urandom_range(0, 3) != 0) begin
			if (r.min_x > r.max_x) {r.min_x, r.max_x} = {r.max_x, r.min_x};
			if (r.min_y > r.max_y) {r.min_y, r.max_y} = {r.max_y, r.min_y};
			if (r.min_z > r.max_z) {r.min_z, r.max_z} = {r.max_z, r.min_z};
		end
		return r;
	endfunction

	function automatic void add_row(req_t r, int h, int v, logic [2:0] pl);
		row_t w;
		w.r = r;
		w.has_exp = (h != 0);
		w.e.visible = (v != 0);
		w.e.rejecting_plane = pl;
		rows.push_back(w);
	endfunction

	task automatic send(req_t r);
		req.valid <= 1'b1;
		req.data <= r;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic send_row(row_t w);
		rsp_t p;
		p = cull_predict(w.r);
		if (w.has_exp && p != w.e) begin
			$error("directed row: predictor gives %0d/%0d, table %0d/%0d",
				p.visible, p.rejecting_plane, w.e.visible, w.e.rejecting_plane);
			errors++;
		end
		cull_expected.push_back(p);
		send(w.r);
	endtask

	task automatic gap();
		req.valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	initial begin
		req_t r;
		req_t z;
		int burst;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		for (int p = 0; p < NUM_PLANES; p++) planes[p] = '0;
		z = '0;

		// reset planes cull at plane 0
		r = z; r.kind = KIND_TEST;
		add_row(r, 1, 0, 3'd0);
		r.min_x = 32'sh80000000; r.min_y = 32'sh80000000; r.min_z = 32'sh80000000;
		r.max_x = 32'sh7fffffff; r.max_y = 32'sh7fffffff; r.max_z = 32'sh7fffffff;
		add_row(r, 1, 0, 3'd0);
		// load index out of range
		r = z; r.plane_index = 3'd6; r.normal_x = 16'sd16384;
		r.plane_offset = -48'sd1;
		add_row(r, 1, 0, PLANE_NONE);
		r.plane_index = 3'd7; r.plane_offset = 48'sh7fffffffffff;
		r.min_x = 32'sh7fffffff;
		add_row(r, 1, 0, PLANE_NONE);
		// six planes, axis-aligned normals, offsets far negative
		for (int p = 0; p < NUM_PLANES; p++) begin
			r = z; r.plane_index = 3'(p);
			r.normal_x = (p == 0) ? 16'sd16384 : (p == 1) ? -16'sd16384 : 16'sd0;
			r.normal_y = (p == 2) ? 16'sd16384 : (p == 3) ? -16'sd16384 : 16'sd0;
			r.normal_z = (p == 4) ? 16'sd16384 : (p == 5) ? -16'sd16384 : 16'sd0;
			r.plane_offset = 48'sh800000000000;
			add_row(r, 1, 0, PLANE_NONE);
		end
		r = z; r.kind = KIND_TEST;
		add_row(r, 1, 1, PLANE_NONE);
		r.min_x = 32'sh80000000; r.min_y = 32'sh80000000; r.min_z = 32'sh80000000;
		r.max_x = 32'sh7fffffff; r.max_y = 32'sh7fffffff; r.max_z = 32'sh7fffffff;
		r.plane_index = 3'd7; r.normal_x = -16'sd1; r.plane_offset = '1;
		add_row(r, 1, 1, PLANE_NONE);
		// plane 3 offset max, culls everything at 3
		r = z; r.plane_index = 3'd3; r.normal_y = -16'sd16384;
		r.plane_offset = 48'sh7fffffffffff;
		add_row(r, 1, 0, PLANE_NONE);
		r = z; r.kind = KIND_TEST;
		add_row(r, 1, 0, 3'd3);
		// swapped corners, random loads and boxes, and a flat box go to the predictor
		r.min_x = 32'sh00100000; r.max_x = -32'sh00100000;
		add_row(r, 0, 0, 3'd0);
		for (int i = 0; i < 6; i++) add_row(rand_req(i % 2 == 0), 0, 0, 3'd0);
		r = z; r.kind = KIND_TEST; r.min_z = 32'sh80000000; r.max_z = 32'sh80000000;
		add_row(r, 0, 0, 3'd0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_row(rows[i]);
			if ($urandom_range(0, 3) == 0) gap();
		end
		req.valid <= 1'b0;

		// sender pauses until everything is back
		while (cull_expected.size() != 0) @(posedge clk);

		// offered stream while the receiver holds off
		hold_long = 1'b1;
		for (int i = 0; i < 20; i++) begin
			r = rand_req($urandom_range(0, 3) == 0);
			cull_expected.push_back(cull_predict(r));
			send(r);
		end
		hold_long = 1'b0;

		for (int n = 0; n < 620;) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst; i++) begin
				r = rand_req($urandom_range(0, 4) == 0);
				cull_expected.push_back(cull_predict(r));
				send(r);
				n++;
			end
			if ($urandom_range(0, 2) != 0) gap();
		end
		req.valid <= 1'b0;
		send_done = 1'b1;
	end

	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				rsp.ready <= 1'b0;
				hold = 0;
				while (hold < 200) begin
					@(posedge clk);
					hold++;
				end
				rsp.ready <= 1'b1;
			end else begin
				case ($urandom_range(0, 9))
					0, 1: rsp.ready <= 1'b0;
					2: if ($urandom_range(0, 3) == 0) rsp.ready <= 1'b0;
					default: rsp.ready <= 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (cull_expected.size() == 0) begin
				$error("response with nothing expected");
				errors++;
			end else begin
				e = cull_expected.pop_front();
				if (rsp.data.visible !== e.visible) begin
					$error("visible: expected %0d, got %0d", e.visible, rsp.data.visible);
					errors++;
				end
				if (rsp.data.rejecting_plane !== e.rejecting_plane) begin
					$error("rejecting_plane: expected %0d, got %0d",
						e.rejecting_plane, rsp.data.rejecting_plane);
					errors++;
				end
			end
		end
	end

	initial begin
		int tail;
		tail = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 200000) begin
				$display("frustum_box_cull_test: done, errors");
				$finish;
			end
			if (send_done && cull_expected.size() == 0) begin
				tail++;
				if (tail > 20) begin
					if (errors == 0)
						$display("frustum_box_cull_test: done, clean");
					else
						$display("frustum_box_cull_test: done, errors");
					$finish;
				end
			end
		end
	end
endmodule

FILE: frustum_box_cull.f
+incdir+design
design/fbc_pkg.sv
design/fbc_if.sv
design/frustum_box_cull.sv
verif/frustum_box_cull_test.sv
